### hdl/ursc_pkg.sv
`default_nettype none

package ursc_pkg;

	localparam int unsigned TRIG_W = 3;

	localparam logic [31:0] ECHO_MIN_RST = 32'd200000;
	localparam logic [31:0] ECHO_MAX_RST = 32'd20000000;
	localparam logic [15:0] PERIOD_RST   = 16'd250;
	localparam logic [31:0] SCALE_RST    = 32'd73015;
	localparam logic        LINK_OK_RST  = 1'b0;

	// shortest usable slot: start tick, trigger drop tick, read tick
	localparam logic [15:0] MIN_PERIOD = 16'd3;

	typedef enum logic [2:0] {
		REG_ECHO_MIN = 3'd0,
		REG_ECHO_MAX = 3'd1,
		REG_PERIOD   = 3'd2,
		REG_SCALE    = 3'd3,
		REG_LINK_OK  = 3'd4
	} cfg_reg_t;

	// per-request control decided at acceptance
	typedef struct packed {
		logic              start;
		logic [TRIG_W-1:0] trig;
		logic [1:0]        active;
		logic              read;
		logic              last;
		logic              ok;
		logic              in_range;
	} ctrl_t;

endpackage

`default_nettype wire

### hdl/ultrasonic_ranging_scan_sequencer.sv
// Scan sequencer for a ring of ultrasonic rangers. Every request is one timer tick
// carrying the capture status and echo time; every request yields exactly one result.
// Tick 1 of a slot raises start_capture and the active sensor's trigger line, the
// slot's last tick (period_ticks, at least 3) turns the echo into a distance in cm
// ((echo_ns * scale_q32) >> 32, saturated to 16 bits, 0 when outside
// [echo_min_ns, echo_max_ns] or when the capture failed) and after the last sensor a
// frame with all distances, error flags and link_ok is presented. One request is
// taken per clock cycle while the output is not stalled by out_ready; a result passes
// through the input stage and then the result register, with the 32x32 echo-times-scale
// multiplier between them. Configuration writes are meant for an idle block.
`default_nettype none

module ultrasonic_ranging_scan_sequencer #(
	parameter int unsigned SENSOR_COUNT = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        capture_ok,
	input  wire logic [31:0] echo_ns,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       trigger_lines,
	output logic             start_capture,
	output logic [1:0]       active_sensor,
	output logic             frame_valid,
	output logic             frame_link_ok,
	output logic [15:0]      dist_center,
	output logic [15:0]      dist_left,
	output logic [15:0]      dist_right,
	output logic [2:0]       capture_errors
);

	localparam int unsigned SEL_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam int unsigned TW    = ursc_pkg::TRIG_W;
	localparam logic [2:0]  LAST3 = 3'(SENSOR_COUNT - 1);
	localparam logic [1:0]  LAST_ACT = LAST3[1:0];

	// configuration registers
	logic [31:0] echo_min_q, echo_max_q, scale_q;
	logic [15:0] period_q;
	logic        link_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_min_q <= ursc_pkg::ECHO_MIN_RST;
			echo_max_q <= ursc_pkg::ECHO_MAX_RST;
			period_q   <= ursc_pkg::PERIOD_RST;
			scale_q    <= ursc_pkg::SCALE_RST;
			link_ok_q  <= ursc_pkg::LINK_OK_RST;
		end else if (cfg_we) begin
			unique case (ursc_pkg::cfg_reg_t'(cfg_index))
				ursc_pkg::REG_ECHO_MIN: echo_min_q <= cfg_data;
				ursc_pkg::REG_ECHO_MAX: echo_max_q <= cfg_data;
				ursc_pkg::REG_PERIOD:   period_q   <= cfg_data[15:0];
				ursc_pkg::REG_SCALE:    scale_q    <= cfg_data;
				ursc_pkg::REG_LINK_OK:  link_ok_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake
	logic v_s1, out_valid_q, adv_out, adv_s1, accept;

	assign adv_out  = !out_valid_q || out_ready;
	assign adv_s1   = v_s1 && adv_out;
	assign in_ready = !v_s1 || adv_out;
	assign accept   = in_valid && in_ready;

	// slot sequencing, decided at acceptance
	logic [15:0]      tick_q, tick_next, period_eff;
	logic [SEL_W-1:0] sensor_q;
	logic [2:0]       cur3;
	ursc_pkg::ctrl_t  ctrl_acc;

	assign tick_next  = tick_q + 16'd1;
	assign period_eff = (period_q < ursc_pkg::MIN_PERIOD) ? ursc_pkg::MIN_PERIOD : period_q;
	assign cur3       = 3'(sensor_q);

	always_comb begin
		ctrl_acc.start    = (tick_next == 16'd1);
		ctrl_acc.read     = !ctrl_acc.start && (tick_next >= period_eff);
		ctrl_acc.last     = (cur3 == LAST3);
		ctrl_acc.active   = cur3[1:0];
		ctrl_acc.ok       = capture_ok;
		ctrl_acc.in_range = (echo_ns >= echo_min_q) && (echo_ns <= echo_max_q);
		for (int g = 0; g < TW; g++)
			ctrl_acc.trig[g] = ctrl_acc.start && (g < SENSOR_COUNT) && (cur3 == 3'(g));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			sensor_q <= '0;
		end else if (accept) begin
			if (ctrl_acc.read) begin
				tick_q   <= '0;
				sensor_q <= ctrl_acc.last ? '0 : sensor_q + SEL_W'(1);
			end else begin
				tick_q <= tick_next;
			end
		end
	end

	// input stage
	ursc_pkg::ctrl_t  ctrl_s1;
	logic [SEL_W-1:0] cur_s1;
	logic [31:0]      echo_s1;
	logic [2:0]       cur3_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1 <= ctrl_acc;
			cur_s1  <= sensor_q;
			echo_s1 <= echo_ns;
		end
	end

	assign cur3_s1 = 3'(cur_s1);

	// distance conversion
	logic [63:0] prod;
	logic [15:0] dist_sat, dist_new;

	assign prod     = 64'(echo_s1) * 64'(scale_q);
	assign dist_sat = (|prod[63:48]) ? 16'hFFFF : prod[47:32];
	assign dist_new = (ctrl_s1.ok && ctrl_s1.in_range) ? dist_sat : 16'd0;

	// per-sensor results
	logic [15:0] dist_q [SENSOR_COUNT];
	logic        err_q  [SENSOR_COUNT];
	logic [15:0] frame_dist [TW];
	logic [TW-1:0] frame_err;

	for (genvar s = 0; s < SENSOR_COUNT; s++) begin : g_sensor
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dist_q[s] <= '0;
				err_q[s]  <= 1'b0;
			end else if (adv_s1 && ctrl_s1.read && (cur3_s1 == 3'(s))) begin
				dist_q[s] <= dist_new;
				err_q[s]  <= !ctrl_s1.ok;
			end
		end
	end

	// frame sees the slot finishing in this request too
	for (genvar g = 0; g < TW; g++) begin : g_frame
		if (g < SENSOR_COUNT) begin : g_on
			logic hit;
			assign hit           = ctrl_s1.read && (cur3_s1 == 3'(g));
			assign frame_dist[g] = hit ? dist_new : dist_q[g];
			assign frame_err[g]  = hit ? !ctrl_s1.ok : err_q[g];
		end else begin : g_off
			assign frame_dist[g] = '0;
			assign frame_err[g]  = 1'b0;
		end
	end

	// result register
	logic [2:0]  trig_q, errs_q;
	logic        start_q, fvalid_q, flink_q;
	logic [1:0]  act_q;
	logic [15:0] dcen_q, dleft_q, dright_q;
	logic        fv;

	assign fv = ctrl_s1.read && ctrl_s1.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			trig_q   <= ctrl_s1.trig;
			start_q  <= ctrl_s1.start;
			act_q    <= ctrl_s1.active;
			fvalid_q <= fv;
			flink_q  <= fv && link_ok_q;
			dcen_q   <= fv ? frame_dist[0] : 16'd0;
			dleft_q  <= fv ? frame_dist[1] : 16'd0;
			dright_q <= fv ? frame_dist[2] : 16'd0;
			errs_q   <= fv ? frame_err : 3'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign trigger_lines  = trig_q;
	assign start_capture  = start_q;
	assign active_sensor  = act_q;
	assign frame_valid    = fvalid_q;
	assign frame_link_ok  = flink_q;
	assign dist_center    = dcen_q;
	assign dist_left      = dleft_q;
	assign dist_right     = dright_q;
	assign capture_errors = errs_q;

	// checks
	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_valid) |-> (active_sensor == LAST_ACT))
		else $error("frame presented outside the last sensor slot");

	a_start_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(start_capture && frame_valid))
		else $error("capture start and frame in the same tick");

	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($onehot0(trigger_lines) && ((trigger_lines == 3'd0) || start_capture)))
		else $error("trigger lines not a single pulse with start");

	a_no_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_valid) |->
			(dist_center == 16'd0 && dist_left == 16'd0 && dist_right == 16'd0
			 && capture_errors == 3'd0 && !frame_link_ok))
		else $error("frame fields set without a frame");

endmodule

`default_nettype wire

### tb/ranging_frame_checker.sv
`default_nettype none

module ranging_frame_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,

	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic        capture_ok,
	input  wire logic [31:0] echo_ns,

	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [2:0]  trigger_lines,
	input  wire logic        start_capture,
	input  wire logic [1:0]  active_sensor,
	input  wire logic        frame_valid,
	input  wire logic        frame_link_ok,
	input  wire logic [15:0] dist_center,
	input  wire logic [15:0] dist_left,
	input  wire logic [15:0] dist_right,
	input  wire logic [2:0]  capture_errors,

	output int unsigned      mismatches,
	output int unsigned      waiting,
	output int unsigned      ticks,
	output int unsigned      frames,
	output int unsigned      err_frames,
	output int unsigned      saturated
);

	localparam logic [1:0] LAST_SENSOR = 2'd2;

	typedef struct packed {
		logic [2:0]  trig;
		logic        start;
		logic [1:0]  active;
		logic        fvalid;
		logic        link;
		logic [15:0] dc;
		logic [15:0] dl;
		logic [15:0] dr;
		logic [2:0]  errs;
	} tick_result_t;

	// register copies
	logic [31:0] lo_ns;
	logic [31:0] hi_ns;
	logic [15:0] period_q;
	logic [31:0] scale_q;
	logic        link_q;

	// scan state
	logic [15:0] slot_tick;
	logic [1:0]  slot_sensor;
	logic [15:0] dist_cm [3];
	logic [2:0]  missed;

	tick_result_t expected_ticks [$];

	int unsigned bad_n = 0;
	int unsigned pending_n = 0;
	int unsigned results_n = 0;
	int unsigned frames_n = 0;
	int unsigned err_frames_n = 0;
	int unsigned sat_n = 0;

	assign mismatches = bad_n;
	assign waiting    = pending_n;
	assign ticks      = results_n;
	assign frames     = frames_n;
	assign err_frames = err_frames_n;
	assign saturated  = sat_n;

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at result %0d: %s got %0h expected %0h",
			results_n, what, got, want);
		bad_n++;
	endtask

	function automatic tick_result_t next_tick_result(logic ok, logic [31:0] echo);
		tick_result_t r;
		logic [15:0] slot_len;
		logic [63:0] prod;
		r = '0;
		slot_len = (period_q < ursc_pkg::MIN_PERIOD) ? ursc_pkg::MIN_PERIOD : period_q;
		r.active = slot_sensor;
		slot_tick = slot_tick + 16'd1;
		if (slot_tick == 16'd1) begin
			r.start = 1'b1;
			r.trig = 3'b001 << slot_sensor;
		end else if (slot_tick >= slot_len) begin
			missed[slot_sensor] = !ok;
			dist_cm[slot_sensor] = '0;
			if (ok && echo >= lo_ns && echo <= hi_ns) begin
				prod = {32'd0, echo} * {32'd0, scale_q};
				if (prod[63:48] != '0) begin
					dist_cm[slot_sensor] = 16'hffff;
					sat_n++;
				end else begin
					dist_cm[slot_sensor] = prod[47:32];
				end
			end
			slot_tick = '0;
			if (slot_sensor == LAST_SENSOR) begin
				slot_sensor = '0;
				r.fvalid = 1'b1;
				r.link = link_q;
				r.dc = dist_cm[0];
				r.dl = dist_cm[1];
				r.dr = dist_cm[2];
				r.errs = missed;
				frames_n++;
				if (missed != '0)
					err_frames_n++;
			end else begin
				slot_sensor = slot_sensor + 2'd1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tick_result_t got;
		tick_result_t want;
		if (!arst_n) begin
			lo_ns = ursc_pkg::ECHO_MIN_RST;
			hi_ns = ursc_pkg::ECHO_MAX_RST;
			period_q = ursc_pkg::PERIOD_RST;
			scale_q = ursc_pkg::SCALE_RST;
			link_q = ursc_pkg::LINK_OK_RST;
			slot_tick = '0;
			slot_sensor = '0;
			for (int i = 0; i < 3; i++)
				dist_cm[i] = '0;
			missed = '0;
			expected_ticks.delete();
			pending_n = 0;
		end else begin
			if (cfg_we) begin
				case (ursc_pkg::cfg_reg_t'(cfg_index))
					ursc_pkg::REG_ECHO_MIN: lo_ns = cfg_data;
					ursc_pkg::REG_ECHO_MAX: hi_ns = cfg_data;
					ursc_pkg::REG_PERIOD:   period_q = cfg_data[15:0];
					ursc_pkg::REG_SCALE:    scale_q = cfg_data;
					ursc_pkg::REG_LINK_OK:  link_q = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.trig = trigger_lines;
				got.start = start_capture;
				got.active = active_sensor;
				got.fvalid = frame_valid;
				got.link = frame_link_ok;
				got.dc = dist_center;
				got.dl = dist_left;
				got.dr = dist_right;
				got.errs = capture_errors;
				if (expected_ticks.size() == 0) begin
					flag_mismatch("result with no request pending", 32'(got.active), 32'd0);
				end else begin
					want = expected_ticks.pop_front();
					if (got.trig !== want.trig)
						flag_mismatch("trigger_lines", 32'(got.trig), 32'(want.trig));
					if (got.start !== want.start)
						flag_mismatch("start_capture", 32'(got.start), 32'(want.start));
					if (got.active !== want.active)
						flag_mismatch("active_sensor", 32'(got.active), 32'(want.active));
					if (got.fvalid !== want.fvalid)
						flag_mismatch("frame_valid", 32'(got.fvalid), 32'(want.fvalid));
					if (got.link !== want.link)
						flag_mismatch("frame_link_ok", 32'(got.link), 32'(want.link));
					if (got.dc !== want.dc)
						flag_mismatch("dist_center", 32'(got.dc), 32'(want.dc));
					if (got.dl !== want.dl)
						flag_mismatch("dist_left", 32'(got.dl), 32'(want.dl));
					if (got.dr !== want.dr)
						flag_mismatch("dist_right", 32'(got.dr), 32'(want.dr));
					if (got.errs !== want.errs)
						flag_mismatch("capture_errors", 32'(got.errs), 32'(want.errs));
				end
				results_n++;
			end
			if (in_valid && in_ready)
				expected_ticks.push_back(next_tick_result(capture_ok, echo_ns));
			pending_n = expected_ticks.size();
		end
	end

endmodule

`default_nettype wire

### tb/ultrasonic_ranging_scan_sequencer_test.sv
`default_nettype none

module ultrasonic_ranging_scan_sequencer_test;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASES      = 12;
	localparam int unsigned PHASE_TICKS = 125;
	localparam int unsigned HOLD_PHASE  = 5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = ursc_pkg::REG_ECHO_MIN;
	logic [31:0] cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        capture_ok = 1'b0;
	logic [31:0] echo_ns = '0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  trigger_lines;
	logic        start_capture;
	logic [1:0]  active_sensor;
	logic        frame_valid;
	logic        frame_link_ok;
	logic [15:0] dist_center;
	logic [15:0] dist_left;
	logic [15:0] dist_right;
	logic [2:0]  capture_errors;

	int unsigned mismatches;
	int unsigned waiting;
	int unsigned ticks;
	int unsigned frames;
	int unsigned err_frames;
	int unsigned saturated;

	// stimulus side view of the echo window, used to aim echoes at its edges
	logic [31:0] cur_min = ursc_pkg::ECHO_MIN_RST;
	logic [31:0] cur_max = ursc_pkg::ECHO_MAX_RST;
	bit          tx_gaps = 1'b1;
	bit          rx_gaps = 1'b1;
	bit          hold_off_req = 1'b0;
	int unsigned settings_n = 0;
	int unsigned stalled_cycles = 0;

	always #2 clk = ~clk;

	ultrasonic_ranging_scan_sequencer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.capture_ok    (capture_ok),
		.echo_ns       (echo_ns),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.trigger_lines (trigger_lines),
		.start_capture (start_capture),
		.active_sensor (active_sensor),
		.frame_valid   (frame_valid),
		.frame_link_ok (frame_link_ok),
		.dist_center   (dist_center),
		.dist_left     (dist_left),
		.dist_right    (dist_right),
		.capture_errors(capture_errors)
	);

	ranging_frame_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.capture_ok    (capture_ok),
		.echo_ns       (echo_ns),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.trigger_lines (trigger_lines),
		.start_capture (start_capture),
		.active_sensor (active_sensor),
		.frame_valid   (frame_valid),
		.frame_link_ok (frame_link_ok),
		.dist_center   (dist_center),
		.dist_left     (dist_left),
		.dist_right    (dist_right),
		.capture_errors(capture_errors),
		.mismatches    (mismatches),
		.waiting       (waiting),
		.ticks         (ticks),
		.frames        (frames),
		.err_frames    (err_frames),
		.saturated     (saturated)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stalled_cycles = 0;
			else
				stalled_cycles++;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("no request or result moved for %0d cycles", STALL_LIMIT);
				$display("** ultrasonic_ranging_scan_sequencer: FAILED **");
				$finish;
			end
		end
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin : drain_results
		int gap;
		wait (arst_n);
		forever begin
			if (hold_off_req) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			gap = rx_gaps ? $urandom_range(0, 10) : 0;
			if (gap > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_reg(ursc_pkg::cfg_reg_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(input logic [31:0] lo, hi, per_word, sc, link_word);
		write_reg(ursc_pkg::REG_ECHO_MIN, lo);
		write_reg(ursc_pkg::REG_ECHO_MAX, hi);
		write_reg(ursc_pkg::REG_PERIOD, per_word);
		write_reg(ursc_pkg::REG_SCALE, sc);
		write_reg(ursc_pkg::REG_LINK_OK, link_word);
		cur_min = lo;
		cur_max = hi;
		settings_n++;
	endtask

	task automatic random_setting();
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] sc;
		logic [31:0] per;
		case ($urandom_range(0, 5))
			0: begin lo = '0; hi = '1; end
			1: begin
				lo = $urandom_range(0, 1000000);
				hi = lo + $urandom_range(0, 30000000);
			end
			// empty window
			2: begin
				hi = $urandom_range(0, 1000000);
				lo = hi + 32'd1 + $urandom_range(0, 1000);
			end
			3: begin lo = $urandom; hi = $urandom; end
			4: begin lo = $urandom; hi = lo; end
			default: begin lo = ursc_pkg::ECHO_MIN_RST; hi = ursc_pkg::ECHO_MAX_RST; end
		endcase
		case ($urandom_range(0, 7))
			0: per = $urandom_range(0, 2);
			1: per = 32'(ursc_pkg::MIN_PERIOD);
			2: per = $urandom_range(20, 40);
			default: per = $urandom_range(3, 10);
		endcase
		case ($urandom_range(0, 5))
			0: sc = '0;
			1: sc = '1;
			2: sc = ursc_pkg::SCALE_RST;
			3: sc = $urandom_range(0, 1 << 20);
			default: sc = $urandom;
		endcase
		// unused upper data bits carry noise
		apply_setting(lo, hi, {16'($urandom), per[15:0]}, sc, {31'($urandom), 1'($urandom)});
	endtask

	function automatic logic [31:0] pick_echo();
		logic [63:0] span;
		span = {32'd0, cur_max} - {32'd0, cur_min} + 64'd1;
		case ($urandom_range(0, 15))
			0, 1: return cur_min;
			2, 3: return cur_max;
			4: return cur_min - 32'd1;
			5: return cur_max + 32'd1;
			6: return '0;
			7: return '1;
			8, 9, 10, 11: if (cur_min <= cur_max)
				return cur_min + 32'({32'd0, $urandom} % span);
			default: ;
		endcase
		return $urandom;
	endfunction

	task automatic offer_tick(logic ok, logic [31:0] echo);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		capture_ok <= ok;
		echo_ns <= echo;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic random_ticks(int unsigned n);
		repeat (n) offer_tick($urandom_range(0, 3) != 0, pick_echo());
	endtask

	// let every pending result come back before touching registers
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// reset settings, slot not yet finished
		random_ticks(6);
		settle();

		// widest window, full scale: zero echo, missed capture
		apply_setting('0, '1, 32'd0, '1, 32'd1);
		offer_tick(1'b1, '1);
		offer_tick(1'b1, '0);
		offer_tick(1'b1, '0);
		offer_tick(1'b1, '1);
		offer_tick(1'b1, 32'h8000_0000);
		offer_tick(1'b0, 32'h1234_5678);
		offer_tick(1'b1, '0);
		offer_tick(1'b1, 32'd1);
		offer_tick(1'b0, '1);
		settle();

		// empty window, zero scale, short period
		apply_setting('1, '0, 32'd2, '0, 32'd0);
		offer_tick(1'b1, '1);
		offer_tick(1'b1, '0);
		offer_tick(1'b1, 32'h0001_0000);
		offer_tick(1'b0, '0);
		offer_tick(1'b1, '1);
		offer_tick(1'b1, 32'h5555_5555);
		settle();

		// longest slot, then the period drops below the running count
		apply_setting(ursc_pkg::ECHO_MIN_RST, ursc_pkg::ECHO_MAX_RST, 32'd65535,
			ursc_pkg::SCALE_RST, 32'd1);
		random_ticks(40);
		settle();
		write_reg(ursc_pkg::REG_PERIOD, 32'd4);

		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			if (ph != 0)
				random_setting();
			tx_gaps = $urandom_range(0, 2) != 0;
			rx_gaps = $urandom_range(0, 2) != 0;
			if (ph == HOLD_PHASE) begin
				tx_gaps = 1'b0;
				hold_off_req = 1'b1;
			end
			random_ticks(PHASE_TICKS);
			settle();
		end

		repeat (8) @(negedge clk);
		$display("covered %0d ticks over %0d settings: %0d frames, %0d with capture errors,",
			ticks, settings_n + 1, frames, err_frames);
		$display("%0d saturated distances, %0d mismatches", saturated, mismatches);
		if (mismatches == 0)
			$display("** ultrasonic_ranging_scan_sequencer: PASSED **");
		else
			$display("** ultrasonic_ranging_scan_sequencer: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
